// ===== hdl/ecc_pkg.sv =====
// Shared types, constants and calendar helper functions for the epoch calendar converter.
// Used by the controller, the datapath and the top level; depends on nothing else.
`default_nettype none

package ecc_pkg;

    localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
    localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
    localparam logic [8:0]  EPOCH_MOD400  = 9'd370;
    localparam logic [1:0]  EPOCH_MOD4    = 2'd2;
    localparam logic [6:0]  LAST_MOD100   = 7'd99;
    localparam logic [8:0]  LAST_MOD400   = 9'd399;
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    // Smallest day count whose seconds no longer fit in 32 bits.
    localparam logic [15:0] SAT_DAYS      = 16'd49711;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_MAR     = 4'd3;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;

    // Reciprocals for the divisions by 86400, 3600 and 60. The dividend is first shifted
    // right by 7, 4 and 2 bits, then multiplied and shifted right by 35, 21 and 14 bits.
    localparam logic [25:0] DAY_RECIP     = 26'd50903317;
    localparam logic [13:0] HOUR_RECIP    = 14'd9321;
    localparam logic [10:0] MIN_RECIP     = 11'd1093;

    typedef enum logic [1:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN
    } t_div_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_DAY,
        ST_REM_DAY,
        ST_DIV_HOUR,
        ST_REM_HOUR,
        ST_DIV_MIN,
        ST_REM_MIN,
        ST_YEAR,
        ST_MONTH,
        ST_ADJ,
        ST_MUL,
        ST_SUM
    } t_state;

    typedef struct packed {
        logic        mode;
        logic [31:0] in_seconds;
        logic [11:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [4:0]  in_hour;
        logic [5:0]  in_minute;
        logic [5:0]  in_second;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_seconds;
        logic [11:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic        overflow;
    } t_out_item;

    typedef struct packed {
        logic     load;
        logic     div_quo;
        logic     div_rem;
        t_div_sel div_next;
        logic     year_step;
        logic     month_step;
        logic     adj;
        logic     mul;
        logic     finish;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic year_done;
        logic month_done;
    } t_stat;

    function automatic logic is_leap(input logic [1:0] m4, input logic [6:0] m100,
                                     input logic [8:0] m400);
        return (m400 == 9'd0) || ((m4 == 2'd0) && (m100 != 7'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            MONTH_FEB:                 len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/epoch_calendar_converter_top.sv =====
// Top level of the epoch calendar converter: controller plus datapath.
// Depends on ecc_pkg, ecc_ctrl and ecc_dpath.
// Seconds to date: division by reciprocal multiplication (quotient and remainder for days,
// hours and minutes), then a walk over the years past 1970, then a walk over the months;
// the result strobe is registered from the end of the month walk.
// Date to seconds: a year walk from 1970, stopping early once the total must saturate, then
// day adjust, multiply and sum, then the registered result strobe.
// Throughput is one transaction at a time; the next one is accepted in the strobe cycle.
// Synchronous active-low reset returns the controller to idle and clears the strobe.
`default_nettype none

module epoch_calendar_converter_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire ecc_pkg::t_in_item i_req,
    output logic                   busy,
    output logic                   o_valid,
    output ecc_pkg::t_out_item     o_result
);
    import ecc_pkg::*;

    // The controller only sequences; all arithmetic and data storage live in the datapath.
    t_cmd  cmd;
    t_stat stat;

    ecc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_req.mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // The datapath captures the request when a transaction is accepted, so the
    // request ports are free to change while the block is busy.
    ecc_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result),
        .o_valid  (o_valid)
    );

endmodule

`default_nettype wire

// ===== hdl/ecc_ctrl.sv =====
// Sequencing state machine of the epoch calendar converter.
// Uses ecc_pkg for the state enum and the command and status structs.
`default_nettype none

module ecc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire logic          i_mode,
    input  wire ecc_pkg::t_stat i_stat,
    output ecc_pkg::t_cmd      o_cmd,
    output logic               busy
);
    import ecc_pkg::*;

    t_state     r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    if (i_mode) begin
                        n_state = ST_DIV_DAY;
                    end else begin
                        n_state = ST_YEAR;
                    end
                end
            end
            ST_DIV_DAY: begin
                o_cmd.div_quo = 1'b1;
                n_state       = ST_REM_DAY;
            end
            ST_REM_DAY: begin
                o_cmd.div_rem  = 1'b1;
                o_cmd.div_next = DIV_HOUR;
                n_state        = ST_DIV_HOUR;
            end
            ST_DIV_HOUR: begin
                o_cmd.div_quo = 1'b1;
                n_state       = ST_REM_HOUR;
            end
            ST_REM_HOUR: begin
                o_cmd.div_rem  = 1'b1;
                o_cmd.div_next = DIV_MIN;
                n_state        = ST_DIV_MIN;
            end
            ST_DIV_MIN: begin
                o_cmd.div_quo = 1'b1;
                n_state       = ST_REM_MIN;
            end
            ST_REM_MIN: begin
                o_cmd.div_rem  = 1'b1;
                o_cmd.div_next = DIV_DAY;
                n_state        = ST_YEAR;
            end
            ST_YEAR: begin
                if (i_stat.year_done) begin
                    n_state = i_stat.mode ? ST_MONTH : ST_ADJ;
                end else begin
                    o_cmd.year_step = 1'b1;
                end
            end
            ST_MONTH: begin
                if (i_stat.month_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.month_step = 1'b1;
                end
            end
            ST_ADJ: begin
                o_cmd.adj = 1'b1;
                n_state   = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not make the block busy");

    a_day_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_DAY) |=> (r_state == ST_REM_DAY))
        else $error("day quotient not followed by its remainder");

    a_month_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MONTH) |-> i_stat.mode)
        else $error("month walk entered for a date-to-seconds transaction");

endmodule

`default_nettype wire

// ===== hdl/ecc_dpath.sv =====
// Datapath of the epoch calendar converter: reciprocal divider, year and month walkers,
// seconds accumulation and the result register. Uses ecc_pkg types and functions.
`default_nettype none

module ecc_dpath (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ecc_pkg::t_in_item i_req,
    input  wire ecc_pkg::t_cmd    i_cmd,
    output ecc_pkg::t_stat        o_stat,
    output ecc_pkg::t_out_item    o_result,
    output logic                  o_valid
);
    import ecc_pkg::*;

    logic        r_mode;
    logic [11:0] r_tgt_year;
    logic [4:0]  r_in_day;
    logic [4:0]  r_in_hour;
    logic [5:0]  r_in_min;
    logic [5:0]  r_in_sec;

    logic [31:0] r_dvd;
    logic [15:0] r_quo;
    t_div_sel    r_div_sel;

    logic [15:0] r_days;
    logic [11:0] r_year;
    logic [1:0]  r_m4;
    logic [6:0]  r_m100;
    logic [8:0]  r_m400;
    logic [3:0]  r_month;
    logic [4:0]  r_hour;
    logic [5:0]  r_min;

    logic        r_early;
    logic [32:0] r_prod;
    logic [16:0] r_hms;

    t_out_item   r_res;
    t_out_item   n_res;
    logic        r_valid;

    logic [16:0] div_d;
    logic [50:0] day_prod;
    logic [26:0] hour_prod;
    logic [20:0] min_prod;
    logic [15:0] quo;
    logic [32:0] back;
    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  mlen;
    logic [33:0] total;
    logic [11:0] cl_year;
    logic [3:0]  cl_month;
    logic [4:0]  cl_day;

    // Quotient by reciprocal multiplication, registered in r_quo; the remainder follows in the next cycle.
    assign day_prod  = 51'(r_dvd[31:7]) * 51'(DAY_RECIP);
    assign hour_prod = 27'(r_dvd[16:4]) * 27'(HOUR_RECIP);
    assign min_prod  = 21'(r_dvd[11:2]) * 21'(MIN_RECIP);

    always_comb begin
        case (r_div_sel)
            DIV_DAY: begin
                div_d = SECS_PER_DAY;
                quo   = day_prod[50:35];
            end
            DIV_HOUR: begin
                div_d = SECS_PER_HOUR;
                quo   = 16'(hour_prod[26:21]);
            end
            default: begin
                div_d = SECS_PER_MIN;
                quo   = 16'(min_prod[20:14]);
            end
        endcase
    end

    assign back = 33'(r_quo) * 33'(div_d);

    assign leap     = is_leap(r_m4, r_m100, r_m400);
    assign year_len = leap ? 9'd366 : 9'd365;
    assign mlen     = month_len(r_month, leap);
    assign total    = {1'b0, r_prod} + 34'(r_hms);

    always_comb begin
        cl_year  = (i_req.in_year < EPOCH_YEAR) ? EPOCH_YEAR : i_req.in_year;
        cl_month = i_req.in_month;
        if (i_req.in_month == 4'd0) begin
            cl_month = 4'd1;
        end else if (i_req.in_month > MONTH_DEC) begin
            cl_month = MONTH_DEC;
        end
        cl_day   = (i_req.in_day == 5'd0) ? 5'd1 : i_req.in_day;
    end

    always_comb begin
        o_stat.mode       = r_mode;
        o_stat.year_done  = r_mode ? (r_days <= 16'(year_len))
                                   : ((r_year >= r_tgt_year) || (r_days >= SAT_DAYS));
        o_stat.month_done = (r_days <= 16'(mlen)) || (r_month == MONTH_DEC);
    end

    always_comb begin
        n_res = '0;
        if (r_mode) begin
            n_res.out_year   = r_year;
            n_res.out_month  = r_month;
            n_res.out_day    = r_days[4:0];
            n_res.out_hour   = r_hour;
            n_res.out_minute = r_min;
            n_res.out_second = r_dvd[5:0];
        end else if (r_early || (total[33:32] != 2'd0)) begin
            n_res.out_seconds = '1;
            n_res.overflow    = 1'b1;
        end else begin
            n_res.out_seconds = total[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_req.mode;
            r_tgt_year <= cl_year;
            r_in_day   <= cl_day;
            r_in_hour  <= i_req.in_hour;
            r_in_min   <= i_req.in_minute;
            r_in_sec   <= i_req.in_second;
            r_dvd      <= i_req.in_seconds;
            r_div_sel  <= DIV_DAY;
            r_days     <= '0;
            r_year     <= EPOCH_YEAR;
            r_m4       <= EPOCH_MOD4;
            r_m100     <= EPOCH_MOD100;
            r_m400     <= EPOCH_MOD400;
            r_month    <= i_req.mode ? 4'd1 : cl_month;
        end
        if (i_cmd.div_quo) begin
            r_quo <= quo;
        end
        if (i_cmd.div_rem) begin
            r_dvd     <= r_dvd - back[31:0];
            r_div_sel <= i_cmd.div_next;
            case (r_div_sel)
                DIV_DAY:  r_days <= r_quo + 16'd1;
                DIV_HOUR: r_hour <= r_quo[4:0];
                default:  r_min  <= r_quo[5:0];
            endcase
        end
        if (i_cmd.year_step) begin
            r_days <= r_mode ? (r_days - 16'(year_len)) : (r_days + 16'(year_len));
            r_year <= r_year + 12'd1;
            r_m4   <= r_m4 + 2'd1;
            r_m100 <= (r_m100 == LAST_MOD100) ? 7'd0 : r_m100 + 7'd1;
            r_m400 <= (r_m400 == LAST_MOD400) ? 9'd0 : r_m400 + 9'd1;
        end
        if (i_cmd.month_step) begin
            r_days  <= r_days - 16'(mlen);
            r_month <= r_month + 4'd1;
        end
        if (i_cmd.adj) begin
            // An early stop of the year walk already means the result saturates.
            r_early <= (r_days >= SAT_DAYS);
            r_days  <= r_days + 16'(days_before(r_month))
                     + 16'(leap && (r_month >= MONTH_MAR)) + 16'(r_in_day) - 16'd1;
        end
        if (i_cmd.mul) begin
            r_prod <= 33'(r_days) * 33'(SECS_PER_DAY);
            r_hms  <= 17'(r_in_hour) * SECS_PER_HOUR + 17'(r_in_min) * SECS_PER_MIN
                    + 17'(r_in_sec);
        end
        if (i_cmd.finish) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
        end
    end

    assign o_result = r_res;
    assign o_valid  = r_valid;

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held for more than one cycle");

    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_res.overflow) |-> (r_res.out_seconds == 32'hFFFF_FFFF))
        else $error("overflow flagged without saturated seconds");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_mode) |-> ((r_res.out_month >= 4'd1) && (r_res.out_month <= MONTH_DEC)
                                 && (r_res.out_day >= 5'd1) && (r_res.out_hour <= 5'd23)
                                 && (r_res.out_seconds == 32'd0)))
        else $error("date result out of range");

endmodule

`default_nettype wire
